// ----- rtl/tts_pkg.sv -----
// Types and constants shared by the tiled texture address generator.
`default_nettype none

package tts_pkg;

   localparam int COORD_W    = 10;
   localparam int PIX_W      = 32;
   localparam int IDX_W      = 20;
   localparam int ADDR_W     = 22;
   localparam int LOG2_W     = 4;
   localparam int BPP_W      = 3;
   localparam int SIZE_W     = 11;
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;
   localparam int TILE_LOG2  = 3;

   localparam logic [BPP_W-1:0] BPP_MIN = 3'd2;
   localparam logic [BPP_W-1:0] BPP_MID = 3'd3;
   localparam logic [BPP_W-1:0] BPP_MAX = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_PADDED_WIDTH_LOG2  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PADDED_HEIGHT_LOG2 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BYTES_PER_PIXEL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CONTENT_WIDTH      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CONTENT_HEIGHT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_BYTE           = 3'd5;

   typedef struct packed {
      logic [LOG2_W-1:0] padded_width_log2;
      logic [LOG2_W-1:0] padded_height_log2;
      logic [BPP_W-1:0]  bytes_per_pixel;
      logic [SIZE_W-1:0] content_width;
      logic [SIZE_W-1:0] content_height;
      logic [BYTE_W-1:0] pad_byte;
   } cfg_type;

   typedef struct packed {
      logic [IDX_W-1:0]  dest_pixel_index;
      logic [ADDR_W-1:0] dest_byte_address;
      logic [PIX_W-1:0]  pixel_out;
      logic              is_padding;
      logic              out_of_range;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/tts_calc.sv -----
// Address, byte order and padding logic for one pixel word.
`default_nettype none

module tts_calc #(
   parameter int MAX_DIM_LOG2 = 10
) (
   input  tts_pkg::cfg_type                  cfg,
   input  logic [tts_pkg::COORD_W-1:0]       pixel_x,
   input  logic [tts_pkg::COORD_W-1:0]       pixel_y,
   input  logic [tts_pkg::PIX_W-1:0]         pixel_in,
   output tts_pkg::rsp_type                  rsp
);
   import tts_pkg::*;

   localparam int CW = (MAX_DIM_LOG2 > COORD_W) ? MAX_DIM_LOG2 : COORD_W;
   localparam logic [LOG2_W-1:0] MIN_L = LOG2_W'(TILE_LOG2);
   localparam logic [LOG2_W-1:0] MAX_L = LOG2_W'(MAX_DIM_LOG2);

   logic [LOG2_W-1:0]      wl;
   logic [LOG2_W-1:0]      hl;
   logic [BPP_W-1:0]       bpp;
   logic [CW-1:0]          x_ext;
   logic [CW-1:0]          y_ext;
   logic [CW-1:0]          h_mask;
   logic [CW-1:0]          fy;
   logic                   oor;
   logic                   pad;
   logic [ADDR_W-1:0]      tile;
   logic [ADDR_W-1:0]      idx;
   logic [ADDR_W-1:0]      addr;
   logic [2*TILE_LOG2-1:0] morton;
   logic [PIX_W-1:0]       src;
   logic [PIX_W-1:0]       swapped;

   always_comb begin
      if (cfg.padded_width_log2 < MIN_L) begin
         wl = MIN_L;
      end else if (cfg.padded_width_log2 > MAX_L) begin
         wl = MAX_L;
      end else begin
         wl = cfg.padded_width_log2;
      end
      if (cfg.padded_height_log2 < MIN_L) begin
         hl = MIN_L;
      end else if (cfg.padded_height_log2 > MAX_L) begin
         hl = MAX_L;
      end else begin
         hl = cfg.padded_height_log2;
      end
      if (cfg.bytes_per_pixel < BPP_MIN) begin
         bpp = BPP_MIN;
      end else if (cfg.bytes_per_pixel > BPP_MAX) begin
         bpp = BPP_MAX;
      end else begin
         bpp = cfg.bytes_per_pixel;
      end

      x_ext  = CW'(pixel_x);
      y_ext  = CW'(pixel_y);
      oor    = ((x_ext >> wl) != '0) || ((y_ext >> hl) != '0);
      h_mask = ~({CW{1'b1}} << hl);
      fy     = h_mask - y_ext;

      tile = (ADDR_W'(fy >> TILE_LOG2) << (wl - MIN_L)) + ADDR_W'(x_ext >> TILE_LOG2);
      for (int b = 0; b < TILE_LOG2; b++) begin
         morton[2*b]   = x_ext[b];
         morton[2*b+1] = fy[b];
      end
      idx = (tile << (2 * TILE_LOG2)) | ADDR_W'(morton);

      case (bpp)
         BPP_MIN: addr = idx << 1;
         BPP_MID: addr = idx + (idx << 1);
         default: addr = idx << 2;
      endcase

      pad = ({1'b0, pixel_x} >= cfg.content_width) || ({1'b0, pixel_y} >= cfg.content_height);
      src = pad ? {4{cfg.pad_byte}} : pixel_in;
      case (bpp)
         BPP_MIN: swapped = {16'h0, src[7:0], src[15:8]};
         BPP_MID: swapped = {8'h0, src[7:0], src[15:8], src[23:16]};
         default: swapped = {src[7:0], src[15:8], src[23:16], src[31:24]};
      endcase

      if (oor) begin
         rsp = '0;
         rsp.out_of_range = 1'b1;
      end else begin
         rsp.dest_pixel_index  = idx[IDX_W-1:0];
         rsp.dest_byte_address = addr;
         rsp.pixel_out         = swapped;
         rsp.is_padding        = pad;
         rsp.out_of_range      = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/texture_tile_swizzle_address_top.sv -----
// Top level of the tiled texture address generator: registers, word stages, checks.
//
//   channel  handshake               payload
//   request  start / busy            req_pixel_x, req_pixel_y, req_pixel_in
//   response rsp_valid (strobe)      rsp_dest_pixel_index, rsp_dest_byte_address,
//                                    rsp_pixel_out, rsp_is_padding, rsp_out_of_range
//   csr      csr_valid / csr_ready   csr_index, csr_data
//
// One word enters per clock; busy stays low. A word taken is registered in the
// input registers, mapped combinationally in the next cycle and captured in the
// result register, then shows on the response ports for exactly one cycle.
// Synchronous reset clears the strobes and loads the register defaults. The
// receiver cannot stall, so nothing is held back.
`default_nettype none

module texture_tile_swizzle_address_top #(
   parameter int MAX_DIM_LOG2 = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tts_pkg::COORD_W-1:0]       req_pixel_x,
   input  logic [tts_pkg::COORD_W-1:0]       req_pixel_y,
   input  logic [tts_pkg::PIX_W-1:0]         req_pixel_in,
   output logic                              rsp_valid,
   output logic [tts_pkg::IDX_W-1:0]         rsp_dest_pixel_index,
   output logic [tts_pkg::ADDR_W-1:0]        rsp_dest_byte_address,
   output logic [tts_pkg::PIX_W-1:0]         rsp_pixel_out,
   output logic                              rsp_is_padding,
   output logic                              rsp_out_of_range,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tts_pkg::CSR_DATA_W-1:0]    csr_data
);
   import tts_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic                 req_valid_ff;
   logic [COORD_W-1:0]   req_x_ff;
   logic [COORD_W-1:0]   req_y_ff;
   logic [PIX_W-1:0]     req_pix_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_PADDED_WIDTH_LOG2:  cfg_in.padded_width_log2  = csr_data[LOG2_W-1:0];
            REG_PADDED_HEIGHT_LOG2: cfg_in.padded_height_log2 = csr_data[LOG2_W-1:0];
            REG_BYTES_PER_PIXEL:    cfg_in.bytes_per_pixel    = csr_data[BPP_W-1:0];
            REG_CONTENT_WIDTH:      cfg_in.content_width      = csr_data[SIZE_W-1:0];
            REG_CONTENT_HEIGHT:     cfg_in.content_height     = csr_data[SIZE_W-1:0];
            REG_PAD_BYTE:           cfg_in.pad_byte           = csr_data[BYTE_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.padded_width_log2  <= LOG2_W'(3);
         cfg_ff.padded_height_log2 <= LOG2_W'(3);
         cfg_ff.bytes_per_pixel    <= BPP_MAX;
         cfg_ff.content_width      <= SIZE_W'(8);
         cfg_ff.content_height     <= SIZE_W'(8);
         cfg_ff.pad_byte           <= '0;
         req_valid_ff              <= 1'b0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         req_valid_ff <= accept;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_x_ff   <= req_pixel_x;
         req_y_ff   <= req_pixel_y;
         req_pix_ff <= req_pixel_in;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   tts_calc #(
      .MAX_DIM_LOG2(MAX_DIM_LOG2)
   ) u_calc (
      .cfg      (cfg_ff),
      .pixel_x  (req_x_ff),
      .pixel_y  (req_y_ff),
      .pixel_in (req_pix_ff),
      .rsp      (rsp_in)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_dest_pixel_index  = rsp_ff.dest_pixel_index;
   assign rsp_dest_byte_address = rsp_ff.dest_byte_address;
   assign rsp_pixel_out         = rsp_ff.pixel_out;
   assign rsp_is_padding        = rsp_ff.is_padding;
   assign rsp_out_of_range      = rsp_ff.out_of_range;

   a_word_advances: assert property (@(posedge clock) disable iff (reset)
      start |=> ##1 rsp_valid)
      else $error("accepted word did not reach the response port");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |->
         (rsp_dest_pixel_index == '0 && rsp_dest_byte_address == '0 &&
          rsp_pixel_out == '0 && !rsp_is_padding))
      else $error("out of range word carries nonzero fields");

   a_addr_bpp4: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_of_range && cfg_ff.bytes_per_pixel == BPP_MAX) |->
         (rsp_dest_byte_address == {rsp_dest_pixel_index, 2'b00}))
      else $error("byte address does not match pixel index at four bytes per pixel");

endmodule

`default_nettype wire

// ----- test/texture_tile_swizzle_address_top_tb.sv -----
// Self-checking testbench for the tiled texture address generator top level.
module texture_tile_swizzle_address_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tts_pkg::*;

   localparam int MAX_LOG2    = 10;
   localparam int MIN_LOG2    = TILE_LOG2;
   localparam int DRAIN_SLACK = 4;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_WORDS = 150;
   localparam int SWEEP_COUNT = 10;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [COORD_W-1:0]    req_pixel_x = '0;
   logic [COORD_W-1:0]    req_pixel_y = '0;
   logic [PIX_W-1:0]      req_pixel_in = '0;
   logic                  rsp_valid;
   logic [IDX_W-1:0]      rsp_dest_pixel_index;
   logic [ADDR_W-1:0]     rsp_dest_byte_address;
   logic [PIX_W-1:0]      rsp_pixel_out;
   logic                  rsp_is_padding;
   logic                  rsp_out_of_range;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   cfg_type tex_cfg;
   rsp_type pending_texels[$];
   rsp_type want;
   int      mismatches = 0;
   int      pixels_sent = 0;
   int      settings_loaded = 0;
   int      pad_seen = 0;
   int      oor_seen = 0;
   int      cycle_count = 0;

   texture_tile_swizzle_address_top #(
      .MAX_DIM_LOG2(MAX_LOG2)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid),
      .rsp_dest_pixel_index(rsp_dest_pixel_index),
      .rsp_dest_byte_address(rsp_dest_byte_address),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_is_padding(rsp_is_padding),
      .rsp_out_of_range(rsp_out_of_range),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int unsigned eff_log2(input logic [LOG2_W-1:0] v);
      if (v < MIN_LOG2) return MIN_LOG2;
      if (v > MAX_LOG2) return MAX_LOG2;
      return v;
   endfunction

   function automatic cfg_type texture_setup(input int wl, input int hl, input int bpp,
                                             input int cw, input int ch, input int pad);
      cfg_type c;
      c.padded_width_log2  = wl[LOG2_W-1:0];
      c.padded_height_log2 = hl[LOG2_W-1:0];
      c.bytes_per_pixel    = bpp[BPP_W-1:0];
      c.content_width      = cw[SIZE_W-1:0];
      c.content_height     = ch[SIZE_W-1:0];
      c.pad_byte           = pad[BYTE_W-1:0];
      return c;
   endfunction

   function automatic rsp_type map_texel(input cfg_type c, input logic [COORD_W-1:0] x,
                                         input logic [COORD_W-1:0] y,
                                         input logic [PIX_W-1:0] pin);
      int unsigned w, h, bpp, fy, tile, idx;
      int          b;
      logic [2*TILE_LOG2-1:0] swz;
      logic        pad;
      rsp_type     r;
      r = '0;
      w = 1 << eff_log2(c.padded_width_log2);
      h = 1 << eff_log2(c.padded_height_log2);
      bpp = (c.bytes_per_pixel < BPP_MIN) ? BPP_MIN :
            (c.bytes_per_pixel > BPP_MAX) ? BPP_MAX : c.bytes_per_pixel;
      if (x >= w || y >= h) begin
         r.out_of_range = 1'b1;
         return r;
      end
      fy = h - 1 - y;
      tile = (fy >> TILE_LOG2) * (w >> TILE_LOG2) + (x >> TILE_LOG2);
      for (b = 0; b < TILE_LOG2; b++) begin
         swz[2*b]   = x[b];
         swz[2*b+1] = fy[b];
      end
      idx = (tile << (2*TILE_LOG2)) + swz;
      r.dest_pixel_index  = idx[IDX_W-1:0];
      r.dest_byte_address = ADDR_W'(idx * bpp);
      pad = (x >= c.content_width) || (y >= c.content_height);
      for (b = 0; b < bpp; b++) begin
         r.pixel_out[8*b +: 8] = pad ? c.pad_byte : pin[8*(bpp-1-b) +: 8];
      end
      r.is_padding = pad;
      return r;
   endfunction

   function automatic cfg_type pick_settings();
      int wl, hl, bpp, cw, ch;
      wl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 10);
      hl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 10);
      bpp = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 4);
      case ($urandom_range(0, 9))
         0: cw = 0;
         1: cw = 2047;
         2: cw = $urandom_range(0, 2047);
         default: cw = $urandom_range(1, 1 << eff_log2(wl[LOG2_W-1:0]));
      endcase
      case ($urandom_range(0, 9))
         0: ch = 0;
         1: ch = 2047;
         2: ch = $urandom_range(0, 2047);
         default: ch = $urandom_range(1, 1 << eff_log2(hl[LOG2_W-1:0]));
      endcase
      return texture_setup(wl, hl, bpp, cw, ch, $urandom_range(0, 255));
   endfunction

   task automatic check_field(input string name, input logic [PIX_W-1:0] exp_v,
                              input logic [PIX_W-1:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
         mismatches++;
      end
   endtask

   task automatic load_settings(input cfg_type c, input bit touch_spare);
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] junk;
      logic [CSR_DATA_W-1:0] data;
      int                    i;
      for (i = 0; i <= (touch_spare ? REG_SPARE_HI : REG_PAD_BYTE); i++) begin
         idx = i[CSR_IDX_W-1:0];
         junk = CSR_DATA_W'($urandom_range(0, (1 << CSR_DATA_W) - 1));
         case (idx)
            REG_PADDED_WIDTH_LOG2: data = {junk[10:4], c.padded_width_log2};
            REG_PADDED_HEIGHT_LOG2: data = {junk[10:4], c.padded_height_log2};
            REG_BYTES_PER_PIXEL: data = {junk[10:3], c.bytes_per_pixel};
            REG_CONTENT_WIDTH: data = c.content_width;
            REG_CONTENT_HEIGHT: data = c.content_height;
            REG_PAD_BYTE: data = {junk[10:8], c.pad_byte};
            default: data = junk;
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= data;
         do @(posedge clock); while (!csr_ready);
         case (idx)
            REG_PADDED_WIDTH_LOG2: tex_cfg.padded_width_log2 = data[LOG2_W-1:0];
            REG_PADDED_HEIGHT_LOG2: tex_cfg.padded_height_log2 = data[LOG2_W-1:0];
            REG_BYTES_PER_PIXEL: tex_cfg.bytes_per_pixel = data[BPP_W-1:0];
            REG_CONTENT_WIDTH: tex_cfg.content_width = data[SIZE_W-1:0];
            REG_CONTENT_HEIGHT: tex_cfg.content_height = data[SIZE_W-1:0];
            REG_PAD_BYTE: tex_cfg.pad_byte = data[BYTE_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
      settings_loaded++;
      @(posedge clock);
   endtask

   task automatic send_texel(input int x, input int y, input logic [PIX_W-1:0] pin);
      start <= 1'b1;
      req_pixel_x <= x[COORD_W-1:0];
      req_pixel_y <= y[COORD_W-1:0];
      req_pixel_in <= pin;
      do @(posedge clock); while (busy);
      pending_texels.push_back(map_texel(tex_cfg, x[COORD_W-1:0], y[COORD_W-1:0], pin));
      pixels_sent++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_texels.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic send_random_texel(input bit allow_gap);
      int w, h, x, y;
      w = 1 << eff_log2(tex_cfg.padded_width_log2);
      h = 1 << eff_log2(tex_cfg.padded_height_log2);
      case ($urandom_range(0, 19))
         0, 1, 2: begin
            x = $urandom_range(0, 1023);
            y = $urandom_range(0, 1023);
         end
         3, 4: begin
            x = (tex_cfg.content_width == 0) ? 0 : tex_cfg.content_width - 1 + $urandom_range(0, 1);
            y = (tex_cfg.content_height == 0) ? 0 : tex_cfg.content_height - 1 + $urandom_range(0, 1);
            if (x > 1023) x = 1023;
            if (y > 1023) y = 1023;
         end
         default: begin
            x = $urandom_range(0, w - 1);
            y = $urandom_range(0, h - 1);
         end
      endcase
      send_texel(x, y, $urandom());
      if (allow_gap && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic test_reset_defaults();
      send_texel(0, 0, 32'h0403_0201);
      send_texel(7, 7, 32'hFFFF_FFFF);
      send_texel(8, 0, 32'h1234_5678);
      send_texel(0, 8, 32'h8765_4321);
      wait_drained();
   endtask

   task automatic test_full_extent();
      load_settings(texture_setup(10, 10, 2, 1024, 1024, 'hFF), 1'b0);
      send_texel(1023, 1023, 32'hA5A5_5A5A);
      send_texel(1023, 0, 32'h5A5A_A5A5);
      send_texel(0, 1023, 32'h0000_0000);
      send_texel(0, 0, 32'hFFFF_FFFF);
      wait_drained();
   endtask

   task automatic test_clamped_settings();
      load_settings(texture_setup(15, 0, 0, 0, 5, 'h3C), 1'b1);
      send_texel(1023, 7, 32'hDEAD_BEEF);
      send_texel(5, 0, 32'hCAFE_F00D);
      send_texel(0, 8, 32'h0BAD_C0DE);
      wait_drained();
   endtask

   task automatic test_oversized_content();
      load_settings(texture_setup(4, 5, 7, 2047, 2047, 'hAA), 1'b1);
      send_texel(15, 31, 32'h1122_3344);
      send_texel(16, 0, 32'h5566_7788);
      send_texel(3, 9, 32'h99AA_BBCC);
      wait_drained();
   endtask

   task automatic test_padding_edge();
      load_settings(texture_setup(6, 3, 3, 33, 3, 'h81), 1'b0);
      send_texel(32, 2, 32'h00C0_FFEE);
      send_texel(33, 2, 32'h00C0_FFEE);
      send_texel(32, 3, 32'h00C0_FFEE);
      send_texel(63, 7, 32'hFF00_FF00);
      wait_drained();
   endtask

   task automatic test_random_mix();
      int  phase, i, hold_at;
      bit  gaps;
      for (phase = 0; phase < SWEEP_COUNT; phase++) begin
         load_settings(pick_settings(), phase % 3 == 0);
         gaps = $urandom_range(0, 3) != 0;
         hold_at = $urandom_range(20, PHASE_WORDS - 20);
         for (i = 0; i < PHASE_WORDS; i++) begin
            if (i == hold_at) wait_drained();
            send_random_texel(gaps);
         end
         wait_drained();
      end
   endtask

   task automatic test_back_to_back();
      int i;
      load_settings(pick_settings(), 1'b0);
      for (i = 0; i < PHASE_WORDS; i++) send_random_texel(1'b0);
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_texels.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual index %h addr %h pix %h",
                     $time, rsp_dest_pixel_index, rsp_dest_byte_address, rsp_pixel_out);
            mismatches++;
         end else begin
            want = pending_texels.pop_front();
            check_field("dest_pixel_index", want.dest_pixel_index, rsp_dest_pixel_index);
            check_field("dest_byte_address", want.dest_byte_address, rsp_dest_byte_address);
            check_field("pixel_out", want.pixel_out, rsp_pixel_out);
            check_field("is_padding", want.is_padding, rsp_is_padding);
            check_field("out_of_range", want.out_of_range, rsp_out_of_range);
            if (rsp_is_padding === 1'b1) pad_seen++;
            if (rsp_out_of_range === 1'b1) oor_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words outstanding", $time, pending_texels.size());
         $display("texture_tile_swizzle_address_top_tb NOT OK");
         $finish;
      end
   end

   initial begin
      tex_cfg = texture_setup(3, 3, 4, 8, 8, 0);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_full_extent();
      test_clamped_settings();
      test_oversized_content();
      test_padding_edge();
      test_random_mix();
      test_back_to_back();
      $display("Mapped %0d pixels under %0d register settings in %0d cycles;",
               pixels_sent, settings_loaded, cycle_count);
      $display("%0d padding and %0d out-of-range words seen, %0d mismatches.",
               pad_seen, oor_seen, mismatches);
      if (mismatches == 0) begin
         $display("texture_tile_swizzle_address_top_tb OK");
      end else begin
         $display("texture_tile_swizzle_address_top_tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/tts_pkg.sv
rtl/tts_calc.sv
rtl/texture_tile_swizzle_address_top.sv
test/texture_tile_swizzle_address_top_tb.sv
